// File: design/cfrt_pkg.sv
// Shared types, codes and constants for the camera frame rotate/translate block.
package cfrt_pkg;

  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned SQRT_STEPS   = 29;
  localparam int unsigned DIV_STEPS    = 15;

  // configuration register indexes
  localparam logic [1:0] REG_HOME_X = 2'd0;
  localparam logic [1:0] REG_HOME_Y = 2'd1;
  localparam logic [1:0] REG_HOME_Z = 2'd2;

  typedef enum logic [2:0] {
    MODE_YAW       = 3'd0,
    MODE_PITCH     = 3'd1,
    MODE_ROLL      = 3'd2,
    MODE_TRANSLATE = 3'd3,
    MODE_STRAFE    = 3'd4,
    MODE_MOVE      = 3'd5,
    MODE_RISE      = 3'd6,
    MODE_HOME      = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_START  = 4'd1,
    OP_CORDIC = 4'd2,
    OP_QUAD   = 4'd3,
    OP_TMUL   = 4'd4,
    OP_TACC   = 4'd5,
    OP_SQ     = 4'd6,
    OP_SQRT   = 4'd7,
    OP_DIVI   = 4'd8,
    OP_DIV    = 4'd9,
    OP_DEND   = 4'd10,
    OP_CROSS  = 4'd11,
    OP_SMUL   = 4'd12,
    OP_SADD   = 4'd13,
    OP_MISC   = 4'd14,
    OP_OUT    = 4'd15
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] k;
    logic [4:0] cnt;
  } cmd_t;

  // atan(2^-i) in degrees, 23 fraction bits
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:  a = 30'd377487360;
      5'd1:  a = 30'd222843801;
      5'd2:  a = 30'd117744544;
      5'd3:  a = 30'd59768969;
      5'd4:  a = 30'd30000467;
      5'd5:  a = 30'd15014858;
      5'd6:  a = 30'd7509261;
      5'd7:  a = 30'd3754860;
      5'd8:  a = 30'd1877459;
      5'd9:  a = 30'd938733;
      5'd10: a = 30'd469367;
      5'd11: a = 30'd234683;
      5'd12: a = 30'd117342;
      5'd13: a = 30'd58671;
      5'd14: a = 30'd29335;
      5'd15: a = 30'd14668;
      5'd16: a = 30'd7334;
      5'd17: a = 30'd3667;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// File: design/camera_frame_rotate_translate_top.sv
// Top level of the camera frame rotate/translate block.
// One request at a time. Yaw, pitch and roll pass from acceptance to result
// valid through an 18-step CORDIC, a quadrant step, the turn products and sums,
// the squares of the three components, a 29-step square root and three divides,
// then the cross products and an output step. Strafe, move and rise run a
// multiply and add per axis, translate and home their position update, each
// before the output step. The sequencer returns to idle as the result is loaded.
// A new request is taken once the sequencer is idle, even while the previous
// result waits in the output register; a further result then holds the
// sequencer in its output step until that register is free.
module camera_frame_rotate_translate_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // turn_degrees, step_amount, offset_x, offset_y, offset_z, zero pad
  input  logic [151:0] in_tdata,
  // mode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, up_x, up_y, up_z,
  // right_x, right_y, right_z
  output logic [239:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import cfrt_pkg::*;

  cmd_t  cmd;
  mode_t mode;

  assign mode = mode_t'(in_tuser);

  cfrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (mode),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cfrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_mode   (mode),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

// File: design/cfrt_ctrl.sv
// Sequencing state machine for the camera frame rotate/translate block.
module cfrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cfrt_pkg::mode_t in_mode,
  output logic           out_tvalid,
  input  logic           out_tready,
  output cfrt_pkg::cmd_t cmd
);
  import cfrt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CORD  = 15'b000000000000010,
    S_QUAD  = 15'b000000000000100,
    S_TMUL  = 15'b000000000001000,
    S_TACC  = 15'b000000000010000,
    S_SQ    = 15'b000000000100000,
    S_SQRT  = 15'b000000001000000,
    S_DIVI  = 15'b000000010000000,
    S_DIV   = 15'b000000100000000,
    S_DEND  = 15'b000001000000000,
    S_CROSS = 15'b000010000000000,
    S_SMUL  = 15'b000100000000000,
    S_SADD  = 15'b001000000000000,
    S_MISC  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    cmd.op    = OP_NONE;
    cmd.k     = k_r;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op  = OP_START;
          cnt_nxt = 5'd0;
          k_nxt   = 2'd0;
          unique case (in_mode)
            MODE_YAW, MODE_PITCH, MODE_ROLL: state_nxt = S_CORD;
            MODE_TRANSLATE, MODE_HOME:       state_nxt = S_MISC;
            default:                         state_nxt = S_SMUL;
          endcase
        end
      end
      S_CORD: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_QUAD;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_QUAD: begin
        cmd.op    = OP_QUAD;
        state_nxt = S_TMUL;
        k_nxt     = 2'd0;
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TACC;
      end
      S_TACC: begin
        cmd.op = OP_TACC;
        if (k_r == 2'd2) begin
          state_nxt = S_SQ;
          k_nxt     = 2'd0;
        end else begin
          state_nxt = S_TMUL;
          k_nxt     = k_r + 2'd1;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (k_r == 2'd2) begin
          state_nxt = S_SQRT;
          k_nxt     = 2'd0;
          cnt_nxt   = 5'd0;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          state_nxt = S_DIVI;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIVI;
        state_nxt = S_DIV;
        cnt_nxt   = 5'd0;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_DEND;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DEND: begin
        cmd.op = OP_DEND;
        if (k_r == 2'd2) begin
          state_nxt = S_CROSS;
          k_nxt     = 2'd0;
        end else begin
          state_nxt = S_DIVI;
          k_nxt     = k_r + 2'd1;
        end
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (k_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_SMUL: begin
        cmd.op    = OP_SMUL;
        state_nxt = S_SADD;
      end
      S_SADD: begin
        cmd.op = OP_SADD;
        if (k_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SMUL;
          k_nxt     = k_r + 2'd1;
        end
      end
      S_MISC: begin
        cmd.op    = OP_MISC;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.op == OP_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 5'd0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result overwritten while previous one pending");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= 5'(SQRT_STEPS - 1)))
    else $error("step counter out of range");

endmodule

// File: design/cfrt_dp.sv
// Datapath: pose registers, CORDIC, turn products, square root, divider, cross, moves.
module cfrt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cfrt_pkg::cmd_t      cmd,
  input  cfrt_pkg::mode_t     in_mode,
  input  logic [151:0]        in_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  output logic [239:0]        out_tdata
);
  import cfrt_pkg::*;

  localparam logic signed [17:0] FULL_TURN = 18'sd46080;
  localparam logic signed [17:0] Q1_TURN   = 18'sd11520;
  localparam logic signed [17:0] Q2_TURN   = 18'sd23040;
  localparam logic signed [17:0] Q3_TURN   = 18'sd34560;
  localparam logic signed [33:0] GAIN      = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647)       return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767)       return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  logic signed [31:0] home_r [3];
  logic signed [31:0] pos_r  [3];
  logic signed [15:0] dir_r  [3];
  logic signed [15:0] up_r   [3];
  logic signed [15:0] rgt_r  [3];
  logic signed [31:0] off_r  [3];
  logic signed [31:0] step_r;
  mode_t              mode_r;
  logic signed [33:0] x_r, y_r, c_r, s_r;
  logic signed [31:0] z_r;
  logic [1:0]         quad_r;
  logic signed [49:0] p_r;
  logic signed [27:0] v_r [3];
  logic [57:0]        sum_r, n_r, root_r;
  logic [43:0]        num_r;
  logic [14:0]        q_r;
  logic [239:0]       out_r;

  // operand selection
  logic signed [15:0] ta [3], tb [3], ca [3], cb [3], fv [3];
  logic               roll;
  logic               yaw;

  assign roll = (mode_r == MODE_ROLL);
  assign yaw  = (mode_r == MODE_YAW);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta[i] = roll ? rgt_r[i] : dir_r[i];
      tb[i] = yaw ? rgt_r[i] : up_r[i];
      ca[i] = yaw ? dir_r[i] : rgt_r[i];
      cb[i] = yaw ? up_r[i] : dir_r[i];
      unique case (mode_r)
        MODE_STRAFE: fv[i] = rgt_r[i];
        MODE_MOVE:   fv[i] = dir_r[i];
        default:     fv[i] = up_r[i];
      endcase
    end
  end

  // angle reduction
  logic signed [17:0] ang, r1, rr, rem;
  logic [1:0]         quad;
  always_comb begin
    ang = 18'($signed(in_tdata[16:0]));
    r1  = ang + FULL_TURN;
    if (ang < 0) rr = (r1 < 0) ? (r1 + FULL_TURN) : r1;
    else         rr = (ang >= FULL_TURN) ? (ang - FULL_TURN) : ang;
    if (rr >= Q3_TURN) begin
      quad = 2'd3; rem = rr - Q3_TURN;
    end else if (rr >= Q2_TURN) begin
      quad = 2'd2; rem = rr - Q2_TURN;
    end else if (rr >= Q1_TURN) begin
      quad = 2'd1; rem = rr - Q1_TURN;
    end else begin
      quad = 2'd0; rem = rr;
    end
  end

  // arithmetic for the current step
  logic signed [33:0] dx, dy, cq, sq;
  logic signed [31:0] at;
  logic signed [49:0] ma, mb, mc, md, tsum, vrnd, sinc;
  logic signed [55:0] vw, vsq;
  logic [57:0]        n0, r0, bitv, trial;
  logic [28:0]        m;
  logic [27:0]        mag;
  logic [43:0]        dsh;
  logic [3:0]         sh;
  logic signed [15:0] qv, tres;
  logic [1:0]         j1, j2;
  logic signed [33:0] x1, x2, x3, x4, ct;
  logic signed [19:0] crnd;
  logic signed [27:0] vk;

  always_comb begin
    dx = y_r >>> cmd.cnt;
    dy = x_r >>> cmd.cnt;
    at = $signed({2'b00, atan_deg(cmd.cnt)});
    unique case (quad_r)
      2'd1:    begin cq = -y_r; sq = x_r;  end
      2'd2:    begin cq = -x_r; sq = -y_r; end
      2'd3:    begin cq = y_r;  sq = -x_r; end
      default: begin cq = x_r;  sq = y_r;  end
    endcase
    if (roll) sq = -sq;
    ma   = 50'(ta[cmd.k]);
    mb   = 50'(c_r);
    mc   = 50'(tb[cmd.k]);
    md   = 50'(s_r);
    tsum = p_r + mc * md;
    vrnd = (tsum + 50'sd524288) >>> 20;
    vk   = v_r[cmd.k];
    vw   = 56'(vk);
    vsq  = vw * vw;
    n0   = (cmd.cnt == 5'd0) ? sum_r : n_r;
    r0   = (cmd.cnt == 5'd0) ? 58'd0 : root_r;
    bitv = 58'd1 << (6'd56 - {cmd.cnt, 1'b0});
    trial = r0 + bitv;
    m    = root_r[28:0];
    mag  = vk[27] ? 28'(-vk) : 28'(vk);
    sh   = 4'd14 - cmd.cnt[3:0];
    dsh  = 44'(m) << sh;
    qv   = $signed({1'b0, q_r});
    tres = (m == 29'd0) ? 16'sd0 : (vk[27] ? -qv : qv);
    unique case (cmd.k)
      2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
      2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
      default: begin j1 = 2'd0; j2 = 2'd1; end
    endcase
    x1   = 34'(ca[j1]);
    x2   = 34'(cb[j2]);
    x3   = 34'(ca[j2]);
    x4   = 34'(cb[j1]);
    ct   = x1 * x2 - x3 * x4;
    crnd = 20'((ct + 34'sd8192) >>> 14);
    sinc = (p_r + 50'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r[0] <= 32'sd0;
      home_r[1] <= 32'sd0;
      home_r[2] <= 32'sd655360;
    end else if (cfg_we && cfg_addr <= REG_HOME_Z) begin
      home_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0] <= 32'sd0;
      pos_r[1] <= 32'sd0;
      pos_r[2] <= 32'sd655360;
      dir_r[0] <= 16'sd0; dir_r[1] <= 16'sd0;   dir_r[2] <= -ONE_Q14;
      up_r[0]  <= 16'sd0; up_r[1]  <= ONE_Q14;  up_r[2]  <= 16'sd0;
      rgt_r[0] <= ONE_Q14; rgt_r[1] <= 16'sd0;  rgt_r[2] <= 16'sd0;
    end else begin
      unique case (cmd.op)
        OP_DEND: begin
          if (roll) rgt_r[cmd.k] <= tres;
          else      dir_r[cmd.k] <= tres;
        end
        OP_CROSS: begin
          if (yaw) rgt_r[cmd.k] <= sat16(crnd);
          else     up_r[cmd.k]  <= sat16(crnd);
        end
        OP_SADD: pos_r[cmd.k] <= sat32(50'(pos_r[cmd.k]) + sinc);
        OP_MISC: begin
          if (mode_r == MODE_HOME) begin
            for (int i = 0; i < 3; i++) pos_r[i] <= home_r[i];
            dir_r[0] <= 16'sd0; dir_r[1] <= 16'sd0;   dir_r[2] <= -ONE_Q14;
            up_r[0]  <= 16'sd0; up_r[1]  <= ONE_Q14;  up_r[2]  <= 16'sd0;
            rgt_r[0] <= ONE_Q14; rgt_r[1] <= 16'sd0;  rgt_r[2] <= 16'sd0;
          end else begin
            for (int i = 0; i < 3; i++)
              pos_r[i] <= sat32(50'(pos_r[i]) + 50'(off_r[i]));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        mode_r   <= in_mode;
        step_r   <= $signed(in_tdata[48:17]);
        off_r[0] <= $signed(in_tdata[80:49]);
        off_r[1] <= $signed(in_tdata[112:81]);
        off_r[2] <= $signed(in_tdata[144:113]);
        quad_r   <= quad;
        z_r      <= $signed({2'b00, rem[13:0], 16'd0});
        x_r      <= GAIN;
        y_r      <= 34'sd0;
      end
      OP_CORDIC: begin
        if (!z_r[31]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end
      end
      OP_QUAD: begin
        c_r <= cq;
        s_r <= sq;
      end
      OP_TMUL: p_r <= ma * mb;
      OP_TACC: v_r[cmd.k] <= vrnd[27:0];
      OP_SQ:   sum_r <= ((cmd.k == 2'd0) ? 58'd0 : sum_r) + 58'($unsigned(vsq));
      OP_SQRT: begin
        if (n0 >= trial) begin
          n_r    <= n0 - trial;
          root_r <= (r0 >> 1) + bitv;
        end else begin
          n_r    <= n0;
          root_r <= r0 >> 1;
        end
      end
      OP_DIVI: begin
        num_r <= 44'({mag, 14'd0}) + 44'(m >> 1);
        q_r   <= 15'd0;
      end
      OP_DIV: begin
        if (num_r >= dsh) begin
          num_r  <= num_r - dsh;
          q_r[sh] <= 1'b1;
        end
      end
      OP_SMUL: p_r <= 50'(fv[cmd.k]) * 50'(step_r);
      OP_OUT: begin
        out_r <= {rgt_r[2], rgt_r[1], rgt_r[0], up_r[2], up_r[1], up_r[0],
                  dir_r[2], dir_r[1], dir_r[0], pos_r[2], pos_r[1], pos_r[0]};
      end
      default: ;
    endcase
  end

  assign out_tdata = out_r;

endmodule

// File: tb/camera_frame_rotate_translate_checker.sv
// Checker for the camera pose block: predicts each pose from the accepted commands and compares.
`timescale 1ns / 100ps
module camera_frame_rotate_translate_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [151:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [239:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  import cfrt_pkg::*;

  localparam longint UNIT = 16384;
  localparam longint FULL_TURN = 46080;
  localparam longint QUARTER_TURN = 11520;
  localparam longint GAIN = 652032874;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef longint vec_t[3];

  longint arctan_q23 [18] = '{377487360, 222843801, 117744544, 59768969, 30000467,
    15014858, 7509261, 3754860, 1877459, 938733, 469367, 234683, 117342, 58671,
    29335, 14668, 7334, 3667};
  string field_name [12] = '{"pos_x", "pos_y", "pos_z", "dir_x", "dir_y", "dir_z",
    "up_x", "up_y", "up_z", "right_x", "right_y", "right_z"};

  vec_t position, direction, up_vec, right_vec, home_pos;
  logic [239:0] expected_poses[$];

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic sin_cos(input longint a, output longint c, output longint s);
    longint r, x, y, z, dx, dy, t;
    longint quad;
    r = a % FULL_TURN;
    if (r < 0) r = r + FULL_TURN;
    quad = r / QUARTER_TURN;
    z = (r % QUARTER_TURN) * 65536;
    x = GAIN;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_q23[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_q23[i];
      end
    end
    case (quad)
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = x;
    s = y;
  endtask

  task automatic rotate_unit(input vec_t a, input vec_t b, input longint c,
                             input longint s, output vec_t res);
    vec_t v;
    longint unsigned sum, len, mag;
    longint q;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = round_shift(a[k] * c + b[k] * s, 20);
      sum = sum + longint'(v[k] * v[k]);
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        res[k] = 0;
      end else begin
        mag = v[k] < 0 ? -v[k] : v[k];
        q = ((mag << 14) + len / 2) / len;
        res[k] = sat(v[k] < 0 ? -q : q, -32768, 32767);
      end
    end
  endtask

  task automatic cross_q14(input vec_t a, input vec_t b, output vec_t res);
    vec_t t;
    t[0] = a[1] * b[2] - a[2] * b[1];
    t[1] = a[2] * b[0] - a[0] * b[2];
    t[2] = a[0] * b[1] - a[1] * b[0];
    for (int k = 0; k < 3; k++) res[k] = sat(round_shift(t[k], 14), -32768, 32767);
  endtask

  task automatic step_along(input vec_t f, input longint amount);
    for (int k = 0; k < 3; k++)
      position[k] = sat(position[k] + round_shift(f[k] * amount, 14), POS_MIN, POS_MAX);
  endtask

  task automatic go_home();
    position = home_pos;
    direction = '{0, 0, -UNIT};
    up_vec = '{0, UNIT, 0};
    right_vec = '{UNIT, 0, 0};
  endtask

  task automatic predict_pose(input mode_t mode, input logic [151:0] d);
    longint ang, amount, c, s;
    vec_t off;
    logic [239:0] pose;
    ang = longint'($signed(d[16:0]));
    amount = longint'($signed(d[48:17]));
    off[0] = longint'($signed(d[80:49]));
    off[1] = longint'($signed(d[112:81]));
    off[2] = longint'($signed(d[144:113]));
    case (mode)
      MODE_YAW: begin
        sin_cos(ang, c, s);
        rotate_unit(direction, right_vec, c, s, direction);
        cross_q14(direction, up_vec, right_vec);
      end
      MODE_PITCH: begin
        sin_cos(ang, c, s);
        rotate_unit(direction, up_vec, c, s, direction);
        cross_q14(right_vec, direction, up_vec);
      end
      MODE_ROLL: begin
        sin_cos(ang, c, s);
        rotate_unit(right_vec, up_vec, c, -s, right_vec);
        cross_q14(right_vec, direction, up_vec);
      end
      MODE_TRANSLATE:
        for (int k = 0; k < 3; k++) position[k] = sat(position[k] + off[k], POS_MIN, POS_MAX);
      MODE_STRAFE: step_along(right_vec, amount);
      MODE_MOVE:   step_along(direction, amount);
      MODE_RISE:   step_along(up_vec, amount);
      default:     go_home();
    endcase
    for (int k = 0; k < 3; k++) begin
      pose[32*k +: 32] = position[k][31:0];
      pose[96 + 16*k +: 16] = direction[k][15:0];
      pose[144 + 16*k +: 16] = up_vec[k][15:0];
      pose[192 + 16*k +: 16] = right_vec[k][15:0];
    end
    expected_poses.push_back(pose);
  endtask

  task automatic check_pose(input logic [239:0] got);
    logic [239:0] want;
    logic [31:0] w, g;
    int lo, wd;
    if (expected_poses.size() == 0) begin
      $display("%0t: unexpected pose %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_poses.pop_front();
    for (int f = 0; f < 12; f++) begin
      lo = f < 3 ? 32 * f : 96 + 16 * (f - 3);
      wd = f < 3 ? 32 : 16;
      w = '0;
      g = '0;
      for (int b = 0; b < wd; b++) begin
        w[b] = want[lo + b];
        g[b] = got[lo + b];
      end
      if (w != g) begin
        $display("%0t: %s expected %h actual %h", $time, field_name[f], w, g);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      home_pos = '{0, 0, 655360};
      go_home();
      expected_poses.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_HOME_X: home_pos[0] = longint'($signed(cfg_wdata));
          REG_HOME_Y: home_pos[1] = longint'($signed(cfg_wdata));
          REG_HOME_Z: home_pos[2] = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_pose(out_tdata);
      if (in_tvalid && in_tready) predict_pose(mode_t'(in_tuser), in_tdata);
    end
    pending = expected_poses.size();
  end

endmodule

// File: tb/camera_frame_rotate_translate_top_tb.sv
// Testbench top for the camera pose block: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module camera_frame_rotate_translate_top_tb;
  import cfrt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TURN_LATENCY = 130;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [239:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_off = 1'b0;
  logic         stall_go = 1'b0;
  int           cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  camera_frame_rotate_translate_top DUT (.*);

  camera_frame_rotate_translate_checker pose_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, held off completely during the long stall
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (TURN_LATENCY) @(posedge clk);
  endtask

  task automatic send_command(input mode_t mode, input logic [16:0] ang,
                              input logic [31:0] amount, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {7'd0, oz, oy, ox, amount, ang};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 400)) - 200) << 12;
    endcase
  endfunction

  task automatic random_commands(input int count);
    mode_t mode;
    logic [16:0] ang;
    for (int n = 0; n < count; n++) begin
      mode = mode_t'($urandom_range(0, 6));
      if ($urandom_range(99) < 4) mode = MODE_HOME;
      case ($urandom_range(4))
        0: ang = 17'($urandom());
        1: ang = 17'($signed($urandom_range(0, 2560)) - 1280);
        default: ang = 17'($signed($urandom_range(0, 92160)) - 46080);
      endcase
      send_command(mode, ang, rand_q16(), rand_q16(), rand_q16(), rand_q16());
    end
  endtask

  task automatic end_phase();
    @(negedge clk);
    in_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every mode, angle edges, wrap, saturation, home
    send_idle_pct = 38;
    recv_idle_pct = 68;
    send_command(MODE_TRANSLATE, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_command(MODE_TRANSLATE, '0, '0, 32'h0000_0001, 32'hffff_ffff, 32'h0);
    send_command(MODE_HOME, 17'h1ffff, 32'hffff_ffff, '1, '1, '1);
    send_command(MODE_YAW, 17'd0, '0, '0, '0, '0);
    send_command(MODE_YAW, 17'd11520, '0, '0, '0, '0);
    send_command(MODE_PITCH, 17'd46080, '0, '0, '0, '0);
    send_command(MODE_ROLL, 17'h1_4c00, '0, '0, '0, '0);
    send_command(MODE_YAW, 17'h1_0000, '0, '0, '0, '0);
    send_command(MODE_PITCH, 17'h0_ffff, '0, '0, '0, '0);
    send_command(MODE_ROLL, 17'd5760, '0, '0, '0, '0);
    send_command(MODE_YAW, 17'd23040, '0, '0, '0, '0);
    send_command(MODE_PITCH, 17'd34560, '0, '0, '0, '0);
    send_command(MODE_STRAFE, '0, 32'h7fff_ffff, '0, '0, '0);
    send_command(MODE_MOVE, '0, 32'h8000_0000, '0, '0, '0);
    send_command(MODE_RISE, '0, 32'h7fff_ffff, '0, '0, '0);
    send_command(MODE_RISE, '0, 32'h8000_0000, '0, '0, '0);
    send_command(MODE_MOVE, '0, 32'h0001_0000, '0, '0, '0);
    send_command(MODE_STRAFE, '0, 32'hffff_0000, '0, '0, '0);
    send_command(MODE_HOME, '0, '0, '0, '0, '0);
    end_phase();

    write_reg(REG_HOME_X, 32'h7fff_ffff);
    write_reg(REG_HOME_Y, 32'h8000_0000);
    write_reg(REG_HOME_Z, 32'h0000_0000);
    send_idle_pct = 38;
    recv_idle_pct = 68;
    send_command(MODE_HOME, '0, '0, '0, '0, '0);
    fork
      random_commands(450);
      begin
        repeat (2000) @(posedge clk);
        stall_go = 1'b1;
      end
    join
    end_phase();

    write_reg(REG_HOME_X, 32'h8000_0000);
    write_reg(REG_HOME_Y, 32'h7fff_ffff);
    write_reg(REG_HOME_Z, $urandom());
    send_idle_pct = 68;
    recv_idle_pct = 38;
    send_command(MODE_HOME, '0, '0, '0, '0, '0);
    random_commands(450);
    end_phase();

    write_reg(REG_HOME_X, $urandom());
    write_reg(REG_HOME_Y, $urandom());
    write_reg(REG_HOME_Z, 32'h000a_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_command(MODE_HOME, '0, '0, '0, '0, '0);
    random_commands(450);
    end_phase();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/cfrt_pkg.sv
design/cfrt_ctrl.sv
design/cfrt_dp.sv
design/camera_frame_rotate_translate_top.sv
tb/camera_frame_rotate_translate_checker.sv
tb/camera_frame_rotate_translate_top_tb.sv
